FILE: rtl/core/pgd_pkg.sv
// Package for the quintic gradient descent block: widths, formats, payload and command types.
// Shared saturation helpers. Depends on nothing.
`default_nettype none

package pgd_pkg;

  localparam int COEFF_W       = 16;
  localparam int FRAC_BITS_DEF = 16;
  localparam int X_W           = 32;
  localparam int W_W           = 48;
  localparam int H_W           = W_W / 2;
  localparam int STEP_W        = 20;
  localparam int EPOCH_W       = 16;
  localparam int K_W           = COEFF_W + 3;
  localparam int A_W           = (K_W > X_W) ? K_W : X_W;
  localparam int P_W           = A_W + W_W;
  localparam int ACC_W         = W_W + 3;
  localparam int DX_W          = W_W + 1;
  localparam int STEP_CNT_W    = 4;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = STEP_W;

  localparam logic [EPOCH_W-1:0] EPOCH_RESET = EPOCH_W'(100);
  localparam logic [STEP_W-1:0]  STEP_RESET  = STEP_W'(655);

  localparam logic [CFG_IDX_W-1:0] CFG_EPOCH_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE   = 1'b1;

  localparam logic signed [W_W-1:0] W_MAX = {1'b0, {(W_W-1){1'b1}}};
  localparam logic signed [W_W-1:0] W_MIN = {1'b1, {(W_W-1){1'b0}}};
  localparam logic signed [X_W-1:0] X_MAX = {1'b0, {(X_W-1){1'b1}}};
  localparam logic signed [X_W-1:0] X_MIN = {1'b1, {(X_W-1){1'b0}}};
  localparam logic [W_W-1:0] MAG_POS_MAX = {1'b0, {(W_W-1){1'b1}}};
  localparam logic [W_W-1:0] MAG_NEG_MAX = {1'b1, {(W_W-1){1'b0}}};

  typedef enum logic [1:0] {
    S_IDLE,
    S_EPOCH,
    S_EVAL
  } state_t;

  typedef enum logic [3:0] {
    SA_X,
    SA_STEP,
    SA_C1,
    SA_C2,
    SA_C3,
    SA_C4,
    SA_C5,
    SA_K2,
    SA_K3,
    SA_K4,
    SA_K5
  } src_a_t;

  typedef enum logic [2:0] {
    SB_X,
    SB_P2,
    SB_P3,
    SB_P4,
    SB_P5,
    SB_D
  } src_b_t;

  typedef enum logic [2:0] {
    D_P2,
    D_P3,
    D_P4,
    D_P5,
    D_ACC,
    D_X
  } dest_t;

  typedef struct packed {
    logic signed [COEFF_W-1:0] coeff_5;
    logic signed [COEFF_W-1:0] coeff_4;
    logic signed [COEFF_W-1:0] coeff_3;
    logic signed [COEFF_W-1:0] coeff_2;
    logic signed [COEFF_W-1:0] coeff_1;
    logic signed [COEFF_W-1:0] coeff_0;
  } pgd_req_t;

  typedef struct packed {
    logic signed [X_W-1:0] min_x;
    logic signed [W_W-1:0] min_y;
    logic                  overflow;
  } pgd_res_t;

  typedef struct packed {
    logic   valid;
    src_a_t src_a;
    src_b_t src_b;
    logic   frac;
    dest_t  dest;
  } pgd_issue_t;

  typedef struct packed {
    logic       load;
    logic       acc_init;
    logic       acc_c0;
    pgd_issue_t issue;
    logic       d_latch;
    logic       finish;
  } pgd_cmd_t;

  typedef struct packed {
    logic                  valid;
    logic                  frac;
    dest_t                 dest;
    logic signed [A_W-1:0] a;
    logic signed [W_W-1:0] b;
  } pgd_op_t;

  typedef struct packed {
    logic           valid;
    logic           neg;
    logic           ovf;
    dest_t          dest;
    logic [W_W-1:0] mag;
  } pgd_prod_t;

  function automatic logic acc_over(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-W_W:0] t;
    t = v[ACC_W-1:W_W-1];
    return (|t) && !(&t);
  endfunction

  function automatic logic signed [W_W-1:0] sat_acc(input logic signed [ACC_W-1:0] v);
    if (acc_over(v)) begin
      return v[ACC_W-1] ? W_MIN : W_MAX;
    end
    return v[W_W-1:0];
  endfunction

  function automatic logic dx_over(input logic signed [DX_W-1:0] v);
    logic [DX_W-X_W:0] t;
    t = v[DX_W-1:X_W-1];
    return (|t) && !(&t);
  endfunction

  function automatic logic signed [X_W-1:0] sat_dx(input logic signed [DX_W-1:0] v);
    if (dx_over(v)) begin
      return v[DX_W-1] ? X_MIN : X_MAX;
    end
    return v[X_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/pgd_mul.sv
// Shared two-stage fixed-point multiplier: sign and magnitude split, two partial products,
// then recombination, truncating shift and saturation. Depends on pgd_pkg.
`default_nettype none

module pgd_mul
  import pgd_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  pgd_op_t   op,
  output pgd_prod_t prod
);

  logic [A_W-1:0]     a_mag;
  logic [W_W-1:0]     b_mag;
  logic [A_W+H_W-1:0] pl_c;
  logic [A_W+H_W-1:0] ph_c;

  logic               s1_valid;
  logic               s1_neg;
  logic               s1_frac;
  dest_t              s1_dest;
  logic [A_W+H_W-1:0] pl;
  logic [A_W+H_W-1:0] ph;

  logic [P_W-1:0]     full;
  logic [P_W-1:0]     shifted;
  logic               hi_nz;
  logic               over;

  always_comb begin
    a_mag = op.a[A_W-1] ? (A_W'(0) - op.a) : op.a;
    b_mag = op.b[W_W-1] ? (W_W'(0) - op.b) : op.b;
    pl_c  = (A_W+H_W)'(a_mag) * (A_W+H_W)'(b_mag[H_W-1:0]);
    ph_c  = (A_W+H_W)'(a_mag) * (A_W+H_W)'(b_mag[W_W-1:H_W]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= op.valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_neg  <= op.a[A_W-1] ^ op.b[W_W-1];
    s1_frac <= op.frac;
    s1_dest <= op.dest;
    pl      <= pl_c;
    ph      <= ph_c;
  end

  always_comb begin
    full    = (P_W'(ph) << H_W) + P_W'(pl);
    shifted = s1_frac ? (full >> FRAC_BITS) : full;
    hi_nz   = |shifted[P_W-1:W_W];
    over    = hi_nz | (s1_neg ? (shifted[W_W-1] & (|shifted[W_W-2:0])) : shifted[W_W-1]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod.valid <= 1'b0;
    end else begin
      prod.valid <= s1_valid;
    end
    prod.neg  <= s1_neg;
    prod.ovf  <= over;
    prod.dest <= s1_dest;
    prod.mag  <= over ? (s1_neg ? MAG_NEG_MAX : MAG_POS_MAX) : shifted[W_W-1:0];
  end

endmodule

`default_nettype wire

FILE: rtl/core/pgd_datapath.sv
// Datapath: coefficient, power, gradient, accumulator and x registers around the shared
// multiplier, driven by controller commands. Depends on pgd_pkg and pgd_mul.
`default_nettype none

module pgd_datapath
  import pgd_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  pgd_cmd_t          cmd,
  input  pgd_req_t          request,
  input  logic [STEP_W-1:0] step_size,
  output pgd_res_t          result
);

  logic signed [COEFF_W-1:0] c0, c1, c2, c3, c4, c5;
  logic signed [K_W-1:0]     k2, k3, k4, k5;
  logic signed [K_W-1:0]     e2, e3, e4, e5;
  logic signed [X_W-1:0]     x;
  logic signed [W_W-1:0]     p2, p3, p4, p5, d;
  logic signed [ACC_W-1:0]   acc;
  logic                      ovf;

  pgd_op_t                   op;
  pgd_prod_t                 prod;

  logic [ACC_W-1:0]          mag_acc;
  logic signed [ACC_W-1:0]   acc_sum;
  logic signed [DX_W-1:0]    xd;
  logic [DX_W-1:0]           xm;
  logic signed [DX_W-1:0]    x_sum;
  logic signed [W_W-1:0]     p_val;
  logic                      prod_ovf;
  logic                      xupd_ovf;
  logic                      dl_ovf;

  always_comb begin
    e2 = K_W'(request.coeff_2);
    e3 = K_W'(request.coeff_3);
    e4 = K_W'(request.coeff_4);
    e5 = K_W'(request.coeff_5);
  end

  always_comb begin
    op.valid = cmd.issue.valid;
    op.frac  = cmd.issue.frac;
    op.dest  = cmd.issue.dest;
    unique case (cmd.issue.src_a)
      SA_X:    op.a = A_W'(x);
      SA_STEP: op.a = A_W'(step_size);
      SA_C1:   op.a = A_W'(c1);
      SA_C2:   op.a = A_W'(c2);
      SA_C3:   op.a = A_W'(c3);
      SA_C4:   op.a = A_W'(c4);
      SA_C5:   op.a = A_W'(c5);
      SA_K2:   op.a = A_W'(k2);
      SA_K3:   op.a = A_W'(k3);
      SA_K4:   op.a = A_W'(k4);
      SA_K5:   op.a = A_W'(k5);
      default: op.a = '0;
    endcase
    unique case (cmd.issue.src_b)
      SB_X:    op.b = W_W'(x);
      SB_P2:   op.b = p2;
      SB_P3:   op.b = p3;
      SB_P4:   op.b = p4;
      SB_P5:   op.b = p5;
      SB_D:    op.b = d;
      default: op.b = '0;
    endcase
  end

  pgd_mul #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mul (
    .clk (clk),
    .rst (rst),
    .op  (op),
    .prod(prod)
  );

  always_comb begin
    mag_acc  = ACC_W'(prod.mag);
    acc_sum  = prod.neg ? (acc - mag_acc) : (acc + mag_acc);
    xd       = DX_W'(x);
    xm       = DX_W'(prod.mag);
    x_sum    = prod.neg ? (xd + xm) : (xd - xm);
    p_val    = prod.neg ? (W_W'(0) - prod.mag) : prod.mag;
    prod_ovf = prod.valid && prod.ovf;
    xupd_ovf = prod.valid && (prod.dest == D_X) && dx_over(x_sum);
    dl_ovf   = cmd.d_latch && acc_over(acc);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      c0 <= request.coeff_0;
      c1 <= request.coeff_1;
      c2 <= request.coeff_2;
      c3 <= request.coeff_3;
      c4 <= request.coeff_4;
      c5 <= request.coeff_5;
      k2 <= e2 <<< 1;
      k3 <= (e3 <<< 1) + e3;
      k4 <= e4 <<< 2;
      k5 <= (e5 <<< 2) + e5;
    end
    if (cmd.acc_init) begin
      acc <= cmd.acc_c0 ? (ACC_W'(c0) <<< FRAC_BITS) : (ACC_W'(c1) <<< FRAC_BITS);
    end
    if (cmd.d_latch) begin
      d <= sat_acc(acc);
    end
    if (cmd.load) begin
      x <= '0;
    end
    if (prod.valid) begin
      unique case (prod.dest)
        D_P2:    p2 <= p_val;
        D_P3:    p3 <= p_val;
        D_P4:    p4 <= p_val;
        D_P5:    p5 <= p_val;
        D_ACC:   acc <= acc_sum;
        D_X:     x <= sat_dx(x_sum);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ovf <= 1'b0;
    end else if (prod_ovf || xupd_ovf || dl_ovf) begin
      ovf <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result.min_x    <= x;
      result.min_y    <= sat_acc(acc);
      result.overflow <= ovf | acc_over(acc);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/pgd_ctrl.sv
// Controller: request handshake, epoch counter and the fixed sixteen-slot schedule that
// issues multiplies and register commands to the datapath. Depends on pgd_pkg.
`default_nettype none

module pgd_ctrl
  import pgd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [EPOCH_W-1:0] epoch_count,
  output logic               busy,
  output logic               done,
  output pgd_cmd_t           cmd
);

  localparam logic [STEP_CNT_W-1:0] SL_SQUARE = STEP_CNT_W'(0);
  localparam logic [STEP_CNT_W-1:0] SL_CUBE   = STEP_CNT_W'(3);
  localparam logic [STEP_CNT_W-1:0] SL_TERM2  = STEP_CNT_W'(4);
  localparam logic [STEP_CNT_W-1:0] SL_TERM1  = STEP_CNT_W'(5);
  localparam logic [STEP_CNT_W-1:0] SL_FOURTH = STEP_CNT_W'(6);
  localparam logic [STEP_CNT_W-1:0] SL_TERM3  = STEP_CNT_W'(7);
  localparam logic [STEP_CNT_W-1:0] SL_FIFTH  = STEP_CNT_W'(9);
  localparam logic [STEP_CNT_W-1:0] SL_TERM4  = STEP_CNT_W'(10);
  localparam logic [STEP_CNT_W-1:0] SL_GRAD   = STEP_CNT_W'(12);
  localparam logic [STEP_CNT_W-1:0] SL_STEP   = STEP_CNT_W'(13);
  localparam logic [STEP_CNT_W-1:0] SL_LAST   = STEP_CNT_W'(15);

  state_t                  state, state_next;
  logic [STEP_CNT_W-1:0]   step, step_next;
  logic [EPOCH_W-1:0]      epochs_left, epochs_left_next;
  logic                    done_next;

  function automatic pgd_issue_t mk_issue(input src_a_t sa, input src_b_t sb,
                                          input logic fr, input dest_t ds);
    pgd_issue_t i;
    i.valid = 1'b1;
    i.src_a = sa;
    i.src_b = sb;
    i.frac  = fr;
    i.dest  = ds;
    return i;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      step        <= '0;
      epochs_left <= '0;
      done        <= 1'b0;
    end else begin
      state       <= state_next;
      step        <= step_next;
      epochs_left <= epochs_left_next;
      done        <= done_next;
    end
  end

  always_comb begin
    state_next       = state;
    step_next        = step;
    epochs_left_next = epochs_left;
    done_next        = 1'b0;
    cmd              = '0;
    unique case (state)
      S_IDLE: begin
        step_next = '0;
        if (start) begin
          cmd.load         = 1'b1;
          epochs_left_next = epoch_count;
          state_next       = (epoch_count == '0) ? S_EVAL : S_EPOCH;
        end
      end
      S_EPOCH: begin
        step_next = step + 1'b1;
        unique case (step)
          SL_SQUARE: begin
            cmd.acc_init = 1'b1;
            cmd.issue    = mk_issue(SA_X, SB_X, 1'b1, D_P2);
          end
          SL_CUBE:   cmd.issue = mk_issue(SA_X, SB_P2, 1'b1, D_P3);
          SL_TERM2:  cmd.issue = mk_issue(SA_K3, SB_P2, 1'b0, D_ACC);
          SL_TERM1:  cmd.issue = mk_issue(SA_K2, SB_X, 1'b0, D_ACC);
          SL_FOURTH: cmd.issue = mk_issue(SA_X, SB_P3, 1'b1, D_P4);
          SL_TERM3:  cmd.issue = mk_issue(SA_K4, SB_P3, 1'b0, D_ACC);
          SL_FIFTH:  cmd.issue = mk_issue(SA_K5, SB_P4, 1'b0, D_ACC);
          SL_GRAD:   cmd.d_latch = 1'b1;
          SL_STEP:   cmd.issue = mk_issue(SA_STEP, SB_D, 1'b1, D_X);
          SL_LAST: begin
            epochs_left_next = epochs_left - 1'b1;
            if (epochs_left == EPOCH_W'(1)) begin
              state_next = S_EVAL;
            end
          end
          default: ;
        endcase
      end
      S_EVAL: begin
        step_next = step + 1'b1;
        unique case (step)
          SL_SQUARE: begin
            cmd.acc_init = 1'b1;
            cmd.acc_c0   = 1'b1;
            cmd.issue    = mk_issue(SA_X, SB_X, 1'b1, D_P2);
          end
          SL_CUBE:   cmd.issue = mk_issue(SA_X, SB_P2, 1'b1, D_P3);
          SL_TERM2:  cmd.issue = mk_issue(SA_C2, SB_P2, 1'b0, D_ACC);
          SL_TERM1:  cmd.issue = mk_issue(SA_C1, SB_X, 1'b0, D_ACC);
          SL_FOURTH: cmd.issue = mk_issue(SA_X, SB_P3, 1'b1, D_P4);
          SL_TERM3:  cmd.issue = mk_issue(SA_C3, SB_P3, 1'b0, D_ACC);
          SL_FIFTH:  cmd.issue = mk_issue(SA_X, SB_P4, 1'b1, D_P5);
          SL_TERM4:  cmd.issue = mk_issue(SA_C4, SB_P4, 1'b0, D_ACC);
          SL_GRAD:   cmd.issue = mk_issue(SA_C5, SB_P5, 1'b0, D_ACC);
          SL_LAST: begin
            cmd.finish = 1'b1;
            done_next  = 1'b1;
            state_next = S_IDLE;
          end
          default: ;
        endcase
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

  a_done_single : assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("Result strobe held for more than one cycle.");
  a_done_idle : assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("Result strobe raised while still busy.");
  a_start_busy : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("Accepted request did not make the block busy.");
  a_epoch_count : assert property (@(posedge clk) disable iff (rst)
    (state == S_EPOCH) |-> (epochs_left != '0))
    else $error("Descent running with no updates left.");

endmodule

`default_nettype wire

FILE: rtl/core/poly5_gradient_descent.sv
// Top level of the quintic gradient descent block: configuration registers, controller and
// datapath. Depends on pgd_pkg, pgd_ctrl and pgd_datapath.
//
//   channel   ports                           handshake
//   request   start, busy, request            beat taken when start is high and busy is low
//   result    done, result                    beat valid for one cycle while done is high
//   config    cfg_we, cfg_index, cfg_data     register written when cfg_we is high
//
// Each descent update runs the dependency chain x, x^2, x^3, x^4,
// gradient, step product, new x through the shared two-stage multiplier.
// A final evaluation of the polynomial at the last x follows, and done rises as it ends;
// a new request is taken in the cycle done is high.
// Reset returns the controller to idle and the registers to 100 updates and step 655.
// The receiver cannot stall: the result beat is presented for exactly one cycle.
`default_nettype none

module poly5_gradient_descent
  import pgd_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  pgd_req_t              request,
  output logic                  done,
  output pgd_res_t              result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [EPOCH_W-1:0] epoch_count;
  logic [STEP_W-1:0]  step_size;
  pgd_cmd_t           cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      epoch_count <= EPOCH_RESET;
      step_size   <= STEP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_EPOCH_COUNT: epoch_count <= cfg_data[EPOCH_W-1:0];
        CFG_STEP_SIZE:   step_size   <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  pgd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .epoch_count(epoch_count),
    .busy       (busy),
    .done       (done),
    .cmd        (cmd)
  );

  pgd_datapath #(
    .FRAC_BITS(FRAC_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .request  (request),
    .step_size(step_size),
    .result   (result)
  );

endmodule

`default_nettype wire

FILE: tb/sv/tb_poly5_gradient_descent.sv
`timescale 1ns / 1ps
// Self-checking testbench for poly5_gradient_descent: a table of directed beats and then
// random phases, each result checked against a fixed answer or an in-bench fixed-point
// descent predictor. Depends on pgd_pkg and the poly5_gradient_descent RTL.

module tb_poly5_gradient_descent;
  import pgd_pkg::*;

  typedef struct {
    bit                    write_reg;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] reg_value;
    pgd_req_t              coeffs;
    bit                    fixed_answer;
    pgd_res_t              answer;
  } plan_row_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  pgd_req_t              request = '0;
  logic                  done;
  pgd_res_t              result;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_EPOCH_COUNT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [EPOCH_W-1:0] epochs_cfg = EPOCH_RESET;
  logic [STEP_W-1:0]  step_cfg = STEP_RESET;
  bit                 sat_seen;
  pgd_res_t           expected_minima[$];
  pgd_res_t           oldest_minimum;
  plan_row_t          directed_plan[$];
  int                 fault_count = 0;

  poly5_gradient_descent DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint clamp_to(longint v, int bits);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      sat_seen = 1'b1;
      return hi;
    end
    if (v < lo) begin
      sat_seen = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // Exact product, magnitude truncated by sh bits, then clamped to a signed width.
  function automatic longint fx_mul(longint a, longint b, int sh, int bits);
    logic [127:0] prod;
    logic [63:0]  ua;
    logic [63:0]  ub;
    logic [63:0]  limit;
    logic [63:0]  mag;
    bit           neg;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    prod = {64'd0, ua} * {64'd0, ub};
    prod = prod >> sh;
    limit = (64'd1 << (bits - 1)) - (neg ? 64'd0 : 64'd1);
    if (prod > {64'd0, limit}) begin
      sat_seen = 1'b1;
      mag = limit;
    end else begin
      mag = prod[63:0];
    end
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic pgd_res_t descend_poly5(pgd_req_t r);
    longint   k5, k4, k3, k2, k1, k0;
    longint   xv, p2, p3, p4, p5, grad, delta, yv, unit;
    pgd_res_t res;
    k5 = r.coeff_5;
    k4 = r.coeff_4;
    k3 = r.coeff_3;
    k2 = r.coeff_2;
    k1 = r.coeff_1;
    k0 = r.coeff_0;
    unit = 64'sd1 <<< FRAC_BITS_DEF;
    sat_seen = 1'b0;
    xv = 0;
    for (int unsigned e = 0; e < epochs_cfg; e++) begin
      p2 = fx_mul(xv, xv, FRAC_BITS_DEF, W_W);
      p3 = fx_mul(p2, xv, FRAC_BITS_DEF, W_W);
      p4 = fx_mul(p3, xv, FRAC_BITS_DEF, W_W);
      grad = fx_mul(5 * k5, p4, 0, W_W) + fx_mul(4 * k4, p3, 0, W_W)
           + fx_mul(3 * k3, p2, 0, W_W) + fx_mul(2 * k2, xv, 0, W_W) + k1 * unit;
      grad = clamp_to(grad, W_W);
      delta = fx_mul(grad, longint'(step_cfg), FRAC_BITS_DEF, W_W);
      xv = clamp_to(xv - delta, X_W);
    end
    p2 = fx_mul(xv, xv, FRAC_BITS_DEF, W_W);
    p3 = fx_mul(p2, xv, FRAC_BITS_DEF, W_W);
    p4 = fx_mul(p3, xv, FRAC_BITS_DEF, W_W);
    p5 = fx_mul(p4, xv, FRAC_BITS_DEF, W_W);
    yv = fx_mul(k5, p5, 0, W_W) + fx_mul(k4, p4, 0, W_W) + fx_mul(k3, p3, 0, W_W)
       + fx_mul(k2, p2, 0, W_W) + fx_mul(k1, xv, 0, W_W) + k0 * unit;
    yv = clamp_to(yv, W_W);
    res.min_x = xv[X_W-1:0];
    res.min_y = yv[W_W-1:0];
    res.overflow = sat_seen;
    return res;
  endfunction

  function automatic pgd_req_t mk_req(int c5, int c4, int c3, int c2, int c1, int c0);
    pgd_req_t r;
    r.coeff_5 = COEFF_W'(c5);
    r.coeff_4 = COEFF_W'(c4);
    r.coeff_3 = COEFF_W'(c3);
    r.coeff_2 = COEFF_W'(c2);
    r.coeff_1 = COEFF_W'(c1);
    r.coeff_0 = COEFF_W'(c0);
    return r;
  endfunction

  // With x left at zero the value is just the constant term.
  function automatic pgd_res_t origin_result(int c0);
    pgd_res_t res;
    res.min_x = '0;
    res.min_y = W_W'(longint'(c0) <<< FRAC_BITS_DEF);
    res.overflow = 1'b0;
    return res;
  endfunction

  function automatic plan_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    plan_row_t row;
    row.write_reg = 1'b1;
    row.reg_index = idx;
    row.reg_value = val;
    row.coeffs = '0;
    row.fixed_answer = 1'b0;
    row.answer = '0;
    return row;
  endfunction

  function automatic plan_row_t coeff_row(pgd_req_t c, bit fixed, pgd_res_t ans);
    plan_row_t row;
    row.write_reg = 1'b0;
    row.reg_index = CFG_EPOCH_COUNT;
    row.reg_value = '0;
    row.coeffs = c;
    row.fixed_answer = fixed;
    row.answer = ans;
    return row;
  endfunction

  function automatic int pick_coeff();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return int'($urandom_range(0, 32)) - 16;
      4, 5:       return int'($urandom_range(0, 1024)) - 512;
      6, 7:       return int'($urandom_range(0, 65535)) - 32768;
      default:    return 0;
    endcase
  endfunction

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    start <= 1'b0;
    while (expected_minima.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_EPOCH_COUNT) begin
      epochs_cfg = val[EPOCH_W-1:0];
    end else begin
      step_cfg = val[STEP_W-1:0];
    end
  endtask

  task automatic issue_request(pgd_req_t r, bit fixed, pgd_res_t ans, bit may_idle);
    bit go;
    request <= r;
    do begin
      go = !(may_idle && $urandom_range(0, 99) < 29);
      start <= go;
      @(posedge clk);
    end while (!(go && !busy));
    expected_minima.push_back(fixed ? ans : descend_poly5(r));
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_minima.size() == 0) begin
        fault_count++;
        if (fault_count <= 10) begin
          $display("Unexpected result beat: min_x=%0d min_y=%0d overflow=%0b",
                   result.min_x, result.min_y, result.overflow);
        end
      end else begin
        oldest_minimum = expected_minima.pop_front();
        if (result.min_x !== oldest_minimum.min_x || result.min_y !== oldest_minimum.min_y ||
            result.overflow !== oldest_minimum.overflow) begin
          fault_count++;
          if (fault_count <= 10) begin
            $display("Result mismatch: expected x=%0d y=%0d ovf=%0b, got x=%0d y=%0d ovf=%0b",
                     oldest_minimum.min_x, oldest_minimum.min_y, oldest_minimum.overflow,
                     result.min_x, result.min_y, result.overflow);
          end
        end
      end
    end
  end

  initial begin
    #100_000_000;
    $display("[poly5_gradient_descent] ERROR");
    $finish;
  end

  initial begin
    int            beat_no;
    int            ep;
    int            stp;
    logic [STEP_W-1:0] full_step;
    full_step = '1;

    directed_plan.push_back(coeff_row(mk_req(0, 0, 0, 0, 0, 0), 1, origin_result(0)));
    directed_plan.push_back(coeff_row(mk_req(0, 0, 0, 0, 0, 32767), 1, origin_result(32767)));
    directed_plan.push_back(coeff_row(mk_req(0, 0, 0, 0, 0, -32768), 1, origin_result(-32768)));
    directed_plan.push_back(coeff_row(mk_req(0, 0, 0, 1, -4, 3), 0, '0));
    directed_plan.push_back(coeff_row(mk_req(1, 0, -3, 0, 1, -7), 0, '0));
    directed_plan.push_back(reg_row(CFG_EPOCH_COUNT, 20'h00000));
    directed_plan.push_back(coeff_row(mk_req(32767, 32767, 32767, 32767, 32767, 32767), 1,
                                      origin_result(32767)));
    directed_plan.push_back(coeff_row(mk_req(-32768, -32768, -32768, -32768, -32768, -32768), 1,
                                      origin_result(-32768)));
    directed_plan.push_back(reg_row(CFG_EPOCH_COUNT, 20'hF0003));
    directed_plan.push_back(reg_row(CFG_STEP_SIZE, full_step));
    directed_plan.push_back(coeff_row(mk_req(0, 0, 0, 0, -32768, 0), 0, '0));
    directed_plan.push_back(coeff_row(mk_req(32767, 32767, 32767, 32767, 32767, 32767), 0, '0));
    directed_plan.push_back(coeff_row(mk_req(-32768, -32768, -32768, -32768, -32768, -32768), 0,
                                      '0));
    directed_plan.push_back(reg_row(CFG_STEP_SIZE, 20'h00000));
    directed_plan.push_back(coeff_row(mk_req(32767, 32767, 32767, 32767, 32767, 32767), 1,
                                      origin_result(32767)));
    directed_plan.push_back(reg_row(CFG_STEP_SIZE, 20'd655));
    directed_plan.push_back(reg_row(CFG_EPOCH_COUNT, 20'd1));
    directed_plan.push_back(coeff_row(mk_req(32767, 0, 0, 0, 100, 5), 0, '0));
    directed_plan.push_back(coeff_row(mk_req(0, -32768, 0, 32767, 0, 0), 0, '0));
    directed_plan.push_back(reg_row(CFG_EPOCH_COUNT, 20'h0FFFF));
    directed_plan.push_back(reg_row(CFG_STEP_SIZE, 20'd1));
    directed_plan.push_back(coeff_row(mk_req(0, 0, 0, 1, -2, 9), 0, '0));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_plan[i]) begin
      if (directed_plan[i].write_reg) begin
        write_register(directed_plan[i].reg_index, directed_plan[i].reg_value);
      end else begin
        issue_request(directed_plan[i].coeffs, directed_plan[i].fixed_answer,
                      directed_plan[i].answer, 1'b1);
      end
    end

    beat_no = 0;
    for (int phase = 0; phase < 10; phase++) begin
      ep = (phase == 3) ? 100 : int'($urandom_range(0, 12));
      case ($urandom_range(0, 3))
        0:       stp = int'($urandom_range(0, 1023));
        1:       stp = int'($urandom_range(0, 20'hFFFFF));
        2:       stp = int'($urandom_range(1024, 16384));
        default: stp = $urandom_range(0, 1) ? 20'hFFFFF : 0;
      endcase
      write_register(CFG_EPOCH_COUNT, {4'($urandom_range(0, 15)), 16'(ep)});
      write_register(CFG_STEP_SIZE, 20'(stp));
      for (int k = 0; k < 50; k++) begin
        issue_request(mk_req(pick_coeff(), pick_coeff(), pick_coeff(), pick_coeff(),
                             pick_coeff(), pick_coeff()),
                      1'b0, '0, !(beat_no >= 200 && beat_no < 300));
        beat_no++;
      end
    end

    start <= 1'b0;
    while (expected_minima.size() != 0) @(posedge clk);
    repeat (16 * (int'(epochs_cfg) + 1) + 16) @(posedge clk);
    if (fault_count == 0) begin
      $display("[poly5_gradient_descent] OK");
    end else begin
      $display("[poly5_gradient_descent] ERROR");
    end
    $finish;
  end

endmodule
